// ----- rtl/dmed_pkg.sv -----
// ----------------------------------------------------------------------------
// dmed_pkg: shared widths for the delta/MSB Elias delta encoder
// Field widths of the sample, code and configuration channels.
// ----------------------------------------------------------------------------
package dmed_pkg;

   localparam int SAMPLE_W = 64;   // raw double bit pattern
   localparam int CODE_W   = 26;   // right-aligned code word
   localparam int LEN_W    = 5;    // number of valid code bits

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [LEN_W-1:0]    len_type;

endpackage

// ----- rtl/dmed_if.sv -----
// ----------------------------------------------------------------------------
// dmed_if: valid/ready channels of the delta/MSB Elias delta encoder
// Sample input, code output and mode register write channels.
// ----------------------------------------------------------------------------
interface dmed_req_if import dmed_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_word;

   modport source (output valid, output sample_word, input ready);
   modport sink   (input valid, input sample_word, output ready);
endinterface

interface dmed_rsp_if import dmed_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type code_bits;
   len_type  code_length;

   modport source (output valid, output code_bits, output code_length, input ready);
   modport sink   (input valid, input code_bits, input code_length, output ready);
endinterface

interface dmed_csr_if ();
   logic valid;
   logic ready;
   logic xor_mode;

   modport source (output valid, output xor_mode, input ready);
   modport sink   (input valid, input xor_mode, output ready);
endinterface

// ----- rtl/delta_msb_elias_delta_encoder.sv -----
// ----------------------------------------------------------------------------
// delta_msb_elias_delta_encoder: top-bits gap coder with Elias delta codes
// Codes the top TOP_BITS of each 64-bit word as a gap from the previous word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one 64-bit word per item; only the top TOP_BITS bits are used.
//   rsp_ch  : one code word per item, right-aligned in code_bits, MSB sent
//             first, with its bit count in code_length.
//   csr_ch  : writes xor_mode (1 = XOR gap, 0 = signed difference). Always
//             ready; write only while no item is in flight.
// Timing: two register stages (input register, result register); the gap
//   subtract, bit-length priority encode and code shift sit between them.
//   One item per cycle sustained while rsp_ch.ready stays high; a result
//   is valid once its item moves into the result register.
// Stalls: when rsp_ch.ready is low the result register holds; the input
//   register still takes one more item, then req_ch.ready drops.
// Reset: clears both stage valids, the first-item flag (set) and xor_mode;
//   the previous top bits read as zero.
// ----------------------------------------------------------------------------
module delta_msb_elias_delta_encoder
   import dmed_pkg::*;
#(
   parameter int TOP_BITS = 16
) (
   input  logic  clock,
   input  logic  reset,
   dmed_req_if.sink   req_ch,
   dmed_rsp_if.source rsp_ch,
   dmed_csr_if.sink   csr_ch
);

   localparam int NW  = TOP_BITS + 1;        // gap + 1
   localparam int LW  = $clog2(NW + 1);      // bit length of n
   localparam int LLW = $clog2(LW + 1);      // bit length of that length
   localparam int CW  = TOP_BITS + 32;       // untruncated code width
   localparam int KW  = $clog2(CW + 1);      // untruncated length width

   // configuration and stream state
   logic                xor_mode_ff, xor_mode_in;
   logic                first_ff, first_in;
   logic [TOP_BITS-1:0] prev_ff, prev_in;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [TOP_BITS-1:0] s1_top_ff, s1_top_in;
   logic [TOP_BITS-1:0] s1_prev_ff, s1_prev_in;
   logic                s1_first_ff, s1_first_in;
   logic                s1_xor_ff, s1_xor_in;

   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   code_type            code_bits_ff, code_bits_in;
   len_type             code_length_ff, code_length_in;

   logic                req_take;
   logic                s1_move;
   logic                rsp_free;
   logic [TOP_BITS-1:0] top_word;

   // coder datapath
   logic                q_gt_p;
   logic [TOP_BITS-1:0] gap;
   logic                neg;
   logic [NW-1:0]       n_val;
   logic [NW-1:0]       n_low;
   logic [LW-1:0]       l_val;
   logic [LLW-1:0]      ll_val;
   logic [KW-1:0]       len_base;
   logic [KW-1:0]       len_full;
   logic [CW-1:0]       code_full;

   assign top_word  = req_ch.sample_word[SAMPLE_W-1 -: TOP_BITS];
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ch.ready = !s1_valid_ff || rsp_free;
   assign req_take  = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      xor_mode_in = csr_ch.valid ? csr_ch.xor_mode : xor_mode_ff;
      first_in    = req_take ? 1'b0 : first_ff;
      prev_in     = req_take ? top_word : prev_ff;

      s1_valid_in = req_take || (s1_valid_ff && !rsp_free);
      s1_top_in   = req_take ? top_word    : s1_top_ff;
      s1_prev_in  = req_take ? prev_ff     : s1_prev_ff;
      s1_first_in = req_take ? first_ff    : s1_first_ff;
      s1_xor_in   = req_take ? xor_mode_ff : s1_xor_ff;
   end

   // gap selection; every case reduces to n = gap + 1 plus an optional lead bit
   always_comb begin
      q_gt_p = s1_top_ff > s1_prev_ff;
      if (s1_first_ff) begin
         gap = s1_top_ff;
         neg = (s1_top_ff == '0);
      end else if (s1_xor_ff) begin
         gap = s1_top_ff ^ s1_prev_ff;
         neg = 1'b0;
      end else if (q_gt_p) begin
         gap = s1_top_ff - s1_prev_ff;
         neg = 1'b0;
      end else begin
         gap = s1_prev_ff - s1_top_ff;
         neg = 1'b1;
      end
      n_val = {1'b0, gap} + NW'(1);
   end

   // priority encodes for bit lengths
   always_comb begin
      l_val = '0;
      for (int i = 0; i < NW; i++) begin
         if (n_val[i]) l_val = LW'(i + 1);
      end
      ll_val = '0;
      for (int j = 0; j < LW; j++) begin
         if (l_val[j]) ll_val = LLW'(j + 1);
      end
   end

   // delta code: (ll-1) zeros, l in binary, low l-1 bits of n
   always_comb begin
      n_low     = n_val & ~(NW'(1) << (l_val - LW'(1)));
      len_base  = (KW'(ll_val) << 1) - KW'(2) + KW'(l_val);
      code_full = (CW'(l_val) << (l_val - LW'(1))) | CW'(n_low)
                | (CW'(neg) << len_base);
      len_full  = len_base + KW'(neg);
   end

   always_comb begin
      rsp_valid_in   = s1_move || (rsp_valid_ff && !rsp_ch.ready);
      code_bits_in   = s1_move ? code_full[CODE_W-1:0] : code_bits_ff;
      code_length_in = s1_move ? len_full[LEN_W-1:0]   : code_length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_mode_ff  <= 1'b0;
         first_ff     <= 1'b1;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         xor_mode_ff  <= xor_mode_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_top_ff      <= s1_top_in;
      s1_prev_ff     <= s1_prev_in;
      s1_first_ff    <= s1_first_in;
      s1_xor_ff      <= s1_xor_in;
      code_bits_ff   <= code_bits_in;
      code_length_ff <= code_length_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.code_bits   = code_bits_ff;
   assign rsp_ch.code_length = code_length_ff;

endmodule

// ----- rtl/dmed_checker.sv -----
// ----------------------------------------------------------------------------
// dmed_checker: port-level checks for the delta/MSB Elias delta encoder
// Watches the channel ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dmed_checker
   import dmed_pkg::*;
#(
   parameter int TOP_BITS = 16
) (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input code_type code_bits,
   input len_type  code_length
);

   // items accepted but not yet delivered (pipeline holds at most two)
   logic [1:0] inflight_ff, inflight_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff + 2'(req_take) - 2'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_bits) && $stable(code_length))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 2'd0)
      else $error("result without an outstanding item");

   // both stages full and the output stalled: nothing more may enter
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("item taken with both stages full");

   if (TOP_BITS <= 16) begin : g_len
      a_len_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid |-> code_length != '0 && code_length <= LEN_W'(CODE_W))
         else $error("code length out of range");
   end

endmodule

bind delta_msb_elias_delta_encoder dmed_checker #(.TOP_BITS(TOP_BITS)) u_dmed_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .code_bits   (rsp_ch.code_bits),
   .code_length (rsp_ch.code_length)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the delta/MSB Elias delta encoder
// Drives 64-bit words through the sample channel with random gaps, stalls the
// code channel at random, and checks every code word and length against a
// behavioral coder of the top 16 bits. Covers the first item, both gap modes
// and mode changes between phases, then long random phases.
// ----------------------------------------------------------------------------
module tb_top;
   import dmed_pkg::*;

   localparam int TOP_BITS = 16;
   localparam int DRAIN_CYCLES = 4;   // two register stages plus margin

   typedef struct packed {
      code_type bits;
      len_type  length;
   } code_entry_type;

   logic clock;
   logic reset;

   dmed_req_if req_ch ();
   dmed_rsp_if rsp_ch ();
   dmed_csr_if csr_ch ();

   delta_msb_elias_delta_encoder #(
      .TOP_BITS(TOP_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // coder state mirrored on the testbench side
   logic                mode_xor;
   logic                seen_first;
   logic [TOP_BITS-1:0] last_top;

   code_entry_type pending_codes[$];
   int unsigned err_count;
   logic calm;                        // no gaps, no stalls

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic int unsigned bit_width(input logic [31:0] v);
      for (int i = 31; i >= 0; i--)
         if (v[i]) return i + 1;
      return 0;
   endfunction

   // Elias delta code of n >= 1
   function automatic void delta_word(input logic [31:0] n, output logic [63:0] code,
                                      output int unsigned len);
      int unsigned l;
      int unsigned ll;
      logic [63:0] low;
      l    = bit_width(n);
      ll   = bit_width(l);
      low  = 64'(n) & ((64'd1 << (l - 1)) - 64'd1);
      len  = (2 * ll - 1) + (l - 1);
      code = (64'(l) << (l - 1)) | low;
   endfunction

   // gap <= 0: leading '1', then delta code of |g|+1
   function automatic void signed_word(input logic [31:0] mag, output logic [63:0] code,
                                       output int unsigned len);
      int unsigned l;
      logic [63:0] c;
      delta_word(mag + 1, c, l);
      code = c | (64'd1 << l);
      len  = l + 1;
   endfunction

   function automatic code_entry_type predict_code(input sample_type word);
      logic [31:0] q;
      logic [31:0] p;
      logic [63:0] code;
      int unsigned len;
      code_entry_type e;
      q = 32'(word[SAMPLE_W-1 -: TOP_BITS]);
      p = 32'(last_top);
      if (!seen_first) begin
         if (q >= 1) delta_word(q + 1, code, len);
         else        signed_word(0, code, len);
      end else if (mode_xor) begin
         delta_word((q ^ p) + 1, code, len);
      end else if (q > p) begin
         delta_word((q - p) + 1, code, len);
      end else begin
         signed_word(p - q, code, len);
      end
      seen_first = 1'b1;
      last_top   = q[TOP_BITS-1:0];
      e.bits   = code[CODE_W-1:0];
      e.length = len[LEN_W-1:0];
      return e;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic sample_type make_word(input logic [TOP_BITS-1:0] top);
      sample_type w;
      w = {$urandom, $urandom};
      w[SAMPLE_W-1 -: TOP_BITS] = top;
      return w;
   endfunction

   task automatic send_sample(input sample_type word);
      int unsigned gap;
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.sample_word <= word;
      do @(posedge clock); while (!req_ch.ready);
      pending_codes.insert(pending_codes.size(), predict_code(word));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   task automatic send_top(input logic [TOP_BITS-1:0] top);
      send_sample(make_word(top));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic value);
      wait_drained();
      @(negedge clock);
      csr_ch.valid    <= 1'b1;
      csr_ch.xor_mode <= value;
      do @(posedge clock); while (!csr_ch.ready);
      mode_xor = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // receiver: random stall stretches on the code channel
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) stall_left = 0;
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) begin
               stall_left = pick_gap();
               if (stall_left == 0) stall_left = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      code_entry_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_codes.size() == 0) begin
            report_error($sformatf("unexpected item bits=%h len=%0d",
                                   rsp_ch.code_bits, rsp_ch.code_length));
         end else begin
            e = pending_codes.pop_front();
            if (rsp_ch.code_bits !== e.bits)
               report_error($sformatf("code_bits got %h exp %h", rsp_ch.code_bits, e.bits));
            if (rsp_ch.code_length !== e.length)
               report_error($sformatf("code_length got %0d exp %0d",
                                      rsp_ch.code_length, e.length));
         end
      end
   end

   // first item ignores the mode; zero codes as "11"
   task automatic test_first_item();
      write_mode(1'b1);
      send_top(16'h0000);
   endtask

   task automatic test_xor_gaps();
      send_top(16'h0000);   // zero gap -> "1"
      send_top(16'hFFFF);
      send_top(16'hFFFF);
      send_top(16'h0000);
      send_top(16'h8000);
      send_top(16'h0001);
      send_top(16'hAAAA);
      send_top(16'h5555);
   endtask

   task automatic test_diff_gaps();
      write_mode(1'b0);
      send_top(16'h5555);   // zero difference -> "11"
      send_top(16'h5556);
      send_top(16'h5555);
      send_top(16'hFFFF);
      send_top(16'h0000);   // largest negative gap, longest code
      send_top(16'hFFFF);   // largest positive gap
      send_top(16'h8000);
      send_top(16'h7FFF);
      send_top(16'h0001);
   endtask

   task automatic test_random_phase(input logic mode, input int unsigned count);
      int unsigned r;
      logic [TOP_BITS-1:0] top;
      write_mode(mode);
      for (int unsigned i = 0; i < count; i++) begin
         calm = (i < count / 5);
         if (i == count / 2) wait_drained();
         r = $urandom_range(0, 9);
         case (r)
            0, 1, 2, 3: top = TOP_BITS'($urandom);
            4, 5, 6: top = last_top + TOP_BITS'($urandom_range(0, 16)) - TOP_BITS'(8);
            7: top = last_top;
            8: begin
               case ($urandom_range(0, 3))
                  0: top = 16'h0000;
                  1: top = 16'hFFFF;
                  2: top = 16'h8000;
                  default: top = 16'h7FFF;
               endcase
            end
            default: top = TOP_BITS'(1) << $urandom_range(0, TOP_BITS - 1);
         endcase
         send_top(top);
      end
      calm = 1'b0;
   endtask

   initial begin
      err_count          = 0;
      calm               = 1'b0;
      mode_xor           = 1'b0;
      seen_first         = 1'b0;
      last_top           = '0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample_word = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.xor_mode    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_item();
      test_xor_gaps();
      test_diff_gaps();
      test_random_phase(1'b0, 255);
      test_random_phase(1'b1, 255);
      test_random_phase(1'b0, 255);
      test_random_phase(1'b1, 255);
      test_random_phase(1'b1, 255);
      test_random_phase(1'b0, 255);

      wait_drained();
      repeat (10) @(posedge clock);
      if (pending_codes.size() != 0)
         report_error($sformatf("%0d items never came out", pending_codes.size()));
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
